[design/serial_api_frame_receiver_assert.svh]
// Assertion macros shared by the frame receiver.
`ifndef SERIAL_API_FRAME_RECEIVER_ASSERT_SVH
`define SERIAL_API_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SAPI_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frame receiver check failed");

// Next-cycle implication, checked outside reset.
`define SAPI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frame receiver check failed");

`endif

[design/sapi_pkg.sv]
// Shared constants and controller/datapath interface types of the frame receiver.
package sapi_pkg;

  localparam int unsigned MaxFrameData = 64;
  localparam int unsigned AddrW        = $clog2(MaxFrameData);
  localparam int unsigned ByteW        = 8;
  localparam int unsigned LenW         = 16;
  localparam int unsigned IndexW       = 6;
  localparam int unsigned FrameLenW    = 7;

  localparam logic [ByteW-1:0] StartByte = 8'h7E;
  localparam logic [ByteW-1:0] SumInit   = 8'hFF;

  typedef struct packed {
    logic start;
    logic len_hi;
    logic len_lo;
    logic data;
    logic check;
    logic skip;
    logic load;
  } sapi_cmd_t;

  typedef struct packed {
    logic is_start;
    logic len_over;
    logic len_zero;
    logic data_done;
    logic sum_ok;
    logic skip_done;
    logic emit_last;
  } sapi_sts_t;

endpackage

[design/sapi_ctrl.sv]
// Frame receiver controller: phase state machine and output beat valid.
module sapi_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  sapi_pkg::sapi_sts_t sts_i,
  output sapi_pkg::sapi_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StWait,
    StLenHi,
    StLenLo,
    StData,
    StCheck,
    StSkip,
    StEmit
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;
  logic   load;

  assign in_ready_o  = (state_q != StEmit);
  assign out_valid_o = out_valid_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign load        = (state_q == StEmit) && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      StWait: begin
        if (in_acc && sts_i.is_start) begin
          cmd_o.start = 1'b1;
          state_d     = StLenHi;
        end
      end
      StLenHi: begin
        if (in_acc) begin
          cmd_o.len_hi = 1'b1;
          state_d      = StLenLo;
        end
      end
      StLenLo: begin
        if (in_acc) begin
          cmd_o.len_lo = 1'b1;
          if (sts_i.len_over) begin
            state_d = StSkip;
          end else if (sts_i.len_zero) begin
            state_d = StCheck;
          end else begin
            state_d = StData;
          end
        end
      end
      StData: begin
        if (in_acc) begin
          cmd_o.data = 1'b1;
          if (sts_i.data_done) begin
            state_d = StCheck;
          end
        end
      end
      StCheck: begin
        if (in_acc) begin
          cmd_o.check = 1'b1;
          state_d     = sts_i.sum_ok ? StEmit : StWait;
        end
      end
      StSkip: begin
        if (in_acc) begin
          cmd_o.skip = 1'b1;
          if (sts_i.skip_done) begin
            state_d = StWait;
          end
        end
      end
      StEmit: begin
        if (load) begin
          cmd_o.load = 1'b1;
          if (sts_i.emit_last) begin
            state_d = StWait;
          end
        end
      end
      default: begin
        state_d = StWait;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StWait;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[design/sapi_dp.sv]
// Frame receiver datapath: length, counters, checksum, frame buffer and output beat.
module sapi_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [sapi_pkg::ByteW-1:0]           rx_byte_i,
  input  sapi_pkg::sapi_cmd_t                  cmd_i,
  output sapi_pkg::sapi_sts_t                  sts_o,
  output logic [sapi_pkg::ByteW-1:0]           frame_byte_o,
  output logic [sapi_pkg::IndexW-1:0]          byte_index_o,
  output logic [sapi_pkg::FrameLenW-1:0]       frame_length_o,
  output logic                                 last_o
);

  logic [sapi_pkg::ByteW-1:0]     frame_mem [sapi_pkg::MaxFrameData];

  logic [sapi_pkg::LenW-1:0]      length_q, length_d;
  logic [sapi_pkg::LenW-1:0]      count_q, count_d;
  logic [sapi_pkg::ByteW-1:0]     sum_q, sum_d;
  logic [sapi_pkg::AddrW-1:0]     rd_idx_q, rd_idx_d;
  logic [sapi_pkg::LenW-1:0]      len_next;
  logic [sapi_pkg::LenW-1:0]      count_inc;
  logic [sapi_pkg::FrameLenW-1:0] rd_idx_inc;

  logic [sapi_pkg::ByteW-1:0]     out_byte_q;
  logic [sapi_pkg::IndexW-1:0]    out_index_q;
  logic [sapi_pkg::FrameLenW-1:0] out_len_q;
  logic                           out_last_q;

  assign len_next   = {length_q[sapi_pkg::LenW-1:sapi_pkg::ByteW], rx_byte_i};
  assign count_inc  = count_q + sapi_pkg::LenW'(1);
  assign rd_idx_inc = sapi_pkg::FrameLenW'(rd_idx_q) + sapi_pkg::FrameLenW'(1);

  assign sts_o.is_start  = (rx_byte_i == sapi_pkg::StartByte);
  assign sts_o.len_over  = (len_next > sapi_pkg::LenW'(sapi_pkg::MaxFrameData));
  assign sts_o.len_zero  = (len_next == '0);
  assign sts_o.data_done = (count_inc >= length_q);
  assign sts_o.sum_ok    = (sum_q == rx_byte_i);
  assign sts_o.skip_done = (count_q == '0);
  assign sts_o.emit_last = (length_q == '0) ||
                           (rd_idx_inc == length_q[sapi_pkg::FrameLenW-1:0]);

  always_comb begin
    length_d = length_q;
    count_d  = count_q;
    sum_d    = sum_q;
    rd_idx_d = rd_idx_q;
    if (cmd_i.start) begin
      count_d = '0;
      sum_d   = sapi_pkg::SumInit;
    end
    if (cmd_i.len_hi) begin
      length_d = {rx_byte_i, sapi_pkg::ByteW'(0)};
    end
    if (cmd_i.len_lo) begin
      length_d = len_next;
      count_d  = sts_o.len_over ? len_next : '0;
    end
    if (cmd_i.data) begin
      sum_d   = sum_q - rx_byte_i;
      count_d = count_inc;
    end
    if (cmd_i.check) begin
      rd_idx_d = '0;
    end
    if (cmd_i.skip && !sts_o.skip_done) begin
      count_d = count_q - sapi_pkg::LenW'(1);
    end
    if (cmd_i.load) begin
      rd_idx_d = rd_idx_inc[sapi_pkg::AddrW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q <= '0;
      count_q  <= '0;
      sum_q    <= sapi_pkg::SumInit;
      rd_idx_q <= '0;
    end else begin
      length_q <= length_d;
      count_q  <= count_d;
      sum_q    <= sum_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.data) begin
      frame_mem[count_q[sapi_pkg::AddrW-1:0]] <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_byte_q  <= frame_mem[rd_idx_q];
      out_index_q <= sapi_pkg::IndexW'(rd_idx_q);
      out_len_q   <= length_q[sapi_pkg::FrameLenW-1:0];
      out_last_q  <= sts_o.emit_last;
    end
  end

  // Empty frame yields a single zero beat.
  assign frame_byte_o   = (out_len_q == '0) ? '0 : out_byte_q;
  assign byte_index_o   = out_index_q;
  assign frame_length_o = out_len_q;
  assign last_o         = out_last_q;

endmodule

[design/serial_api_frame_receiver.sv]
// Top level of the serial API frame receiver.
// Slave channel: one received serial byte per beat on s_axis_tdata.
// The block hunts for the 0x7E start byte, reads a big-endian 16-bit length,
// buffers up to 64 data bytes and checks the closing checksum byte.
// Master channel: a verified frame leaves as a burst of beats, one per data
// byte, with byte_index, frame_length and tlast on the final beat; an empty
// verified frame gives one zero beat with tlast. Bad or oversized frames give
// nothing; oversized ones are consumed byte by byte without being stored.
// Throughput: one input byte per cycle while receiving. After the checksum
// beat the block reads the frame buffer one output beat at a time (at least
// one beat) through its single read port; s_axis_tready is low for that
// burst and rises again as the final beat is loaded into the output register.
// After a good checksum the first beat loads once the output register is free.
// A stalled master side holds the output beat and, during a burst, holds the
// buffer read; the slave side stays stalled until the burst is fully loaded.
// Reset returns to start-byte hunting with no output pending.
`include "serial_api_frame_receiver_assert.svh"

module serial_api_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] frame_byte, [13:8] byte_index,
                                      // [20:14] frame_length, [23:21] zero
  output logic        m_axis_tlast
);

  sapi_pkg::sapi_cmd_t                 cmd;
  sapi_pkg::sapi_sts_t                 sts;
  logic [sapi_pkg::ByteW-1:0]          frame_byte;
  logic [sapi_pkg::IndexW-1:0]         byte_index;
  logic [sapi_pkg::FrameLenW-1:0]      frame_length;

  sapi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sapi_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_byte_i      (s_axis_tdata),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .frame_byte_o   (frame_byte),
    .byte_index_o   (byte_index),
    .frame_length_o (frame_length),
    .last_o         (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, frame_length, byte_index, frame_byte};

  `SAPI_ASSERT_NEXT(a_burst_continues,
                    m_axis_tvalid && m_axis_tready && !m_axis_tlast,
                    m_axis_tvalid)
  `SAPI_ASSERT_SAME(a_mid_index_range,
                    m_axis_tvalid && !m_axis_tlast,
                    ({1'b0, byte_index} + 7'd1) < frame_length)
  `SAPI_ASSERT_SAME(a_last_index,
                    m_axis_tvalid && m_axis_tlast && (frame_length != 7'd0),
                    ({1'b0, byte_index} + 7'd1) == frame_length)
  `SAPI_ASSERT_SAME(a_empty_beat,
                    m_axis_tvalid && (frame_length == 7'd0),
                    m_axis_tlast && (byte_index == 6'd0) && (frame_byte == 8'd0))

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the serial API frame receiver: byte stream in, frame beats out.
`timescale 1ns / 1ps

module tb_top;

  typedef enum logic [2:0] {
    RxHunt,
    RxLenHi,
    RxLenLo,
    RxData,
    RxCheck,
    RxSkip
  } rx_phase_e;

  typedef struct packed {
    logic [sapi_pkg::ByteW-1:0]     data;
    logic [sapi_pkg::IndexW-1:0]    idx;
    logic [sapi_pkg::FrameLenW-1:0] len;
    logic                           last;
  } frame_beat_t;

  localparam int unsigned NoiseMark   = 32'hFFFF_FFFF;
  localparam int          WatchLimit  = 4000;
  localparam int          RandomBytes = 90;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  serial_api_frame_receiver u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial forever #2 clk_i = ~clk_i;

  // Pending serial bytes; NoiseMark entries hold the sender until all beats drain.
  int unsigned rx_q[$];
  frame_beat_t verified_beats_q[$];

  rx_phase_e                 rx_phase = RxHunt;
  logic [sapi_pkg::LenW-1:0] len_word = '0;
  logic [sapi_pkg::LenW-1:0] byte_cnt = '0;
  logic [7:0]                run_sum = sapi_pkg::SumInit;
  logic [7:0]                frame_buf [sapi_pkg::MaxFrameData];

  int err_cnt = 0;
  int beats_checked = 0;
  int n_verified = 0;
  int n_dropped = 0;
  int n_oversized = 0;
  int sent_cnt = 0;
  int stim_total = 0;
  int src_gap = 0;
  int sink_gap = 0;
  int idle_cyc = 0;

  logic quiet;
  assign quiet = ((sent_cnt % 200) >= 150) || (sent_cnt + 120 >= stim_total);

  function automatic void parse_rx_byte(input logic [7:0] b);
    int unsigned k;
    case (rx_phase)
      RxLenHi: begin
        len_word = {b, 8'h00};
        rx_phase = RxLenLo;
      end
      RxLenLo: begin
        len_word = {len_word[15:8], b};
        byte_cnt = '0;
        if (len_word > sapi_pkg::LenW'(sapi_pkg::MaxFrameData)) begin
          byte_cnt = len_word;
          rx_phase = RxSkip;
          n_oversized++;
        end else if (len_word == '0) begin
          rx_phase = RxCheck;
        end else begin
          rx_phase = RxData;
        end
      end
      RxData: begin
        frame_buf[byte_cnt[sapi_pkg::AddrW-1:0]] = b;
        run_sum = run_sum - b;
        byte_cnt = byte_cnt + sapi_pkg::LenW'(1);
        if (byte_cnt >= len_word) rx_phase = RxCheck;
      end
      RxCheck: begin
        run_sum = run_sum - b;
        if (run_sum == '0) begin
          n_verified++;
          if (len_word == '0) begin
            verified_beats_q.push_back('{'0, '0, '0, 1'b1});
          end else begin
            for (k = 0; k < 32'(len_word); k++) begin
              verified_beats_q.push_back('{frame_buf[k[sapi_pkg::AddrW-1:0]],
                                           sapi_pkg::IndexW'(k),
                                           sapi_pkg::FrameLenW'(len_word),
                                           (k + 1 == 32'(len_word))});
            end
          end
        end else begin
          n_dropped++;
        end
        rx_phase = RxHunt;
        byte_cnt = '0;
        run_sum = sapi_pkg::SumInit;
      end
      RxSkip: begin
        if (byte_cnt == '0) begin
          rx_phase = RxHunt;
          run_sum = sapi_pkg::SumInit;
        end else begin
          byte_cnt = byte_cnt - sapi_pkg::LenW'(1);
        end
      end
      default: begin
        rx_phase = RxHunt;
        if (b == sapi_pkg::StartByte) begin
          run_sum = sapi_pkg::SumInit;
          byte_cnt = '0;
          rx_phase = RxLenHi;
        end
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  // fill < 0: random data bytes; otherwise every data byte takes that value
  task automatic add_frame(input int unsigned len, input bit good, input int fill);
    logic [7:0] sum;
    logic [7:0] b;
    sum = sapi_pkg::SumInit;
    rx_q.push_back(32'(sapi_pkg::StartByte));
    rx_q.push_back(32'(len[15:8]));
    rx_q.push_back(32'(len[7:0]));
    if (len > sapi_pkg::MaxFrameData) begin
      repeat (len + 1) rx_q.push_back($urandom_range(0, 255));
    end else begin
      repeat (len) begin
        b = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
        sum = sum - b;
        rx_q.push_back(32'(b));
      end
      rx_q.push_back(32'(good ? sum : sum ^ 8'($urandom_range(1, 255))));
    end
  endtask

  task automatic add_noise(input int unsigned n);
    logic [7:0] b;
    repeat (n) begin
      do b = 8'($urandom_range(0, 255)); while (b == sapi_pkg::StartByte);
      rx_q.push_back(32'(b));
    end
  endtask

  // Sender: hold on stall, advance on accept, idle in bursts outside quiet windows.
  always @(posedge clk_i or negedge rst_ni) begin : drive_rx
    logic nxt_valid;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_rx_byte(s_axis_tdata);
        sent_cnt <= sent_cnt + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        nxt_valid = 1'b0;
        if (src_gap != 0) begin
          src_gap--;
        end else if (rx_q.size() != 0 && rx_q[0] == NoiseMark) begin
          if (verified_beats_q.size() == 0) void'(rx_q.pop_front());
        end else if (rx_q.size() != 0) begin
          if (!quiet && $urandom_range(0, 5) == 0) begin
            src_gap = int'($urandom_range(0, 13));
          end else begin
            nxt_valid = 1'b1;
            s_axis_tdata <= 8'(rx_q.pop_front());
          end
        end
        s_axis_tvalid <= nxt_valid;
      end
    end
  end

  // Receiver: check each accepted beat, stall in bursts outside quiet windows.
  always @(posedge clk_i or negedge rst_ni) begin : watch_frames
    frame_beat_t exp_beat;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        beats_checked++;
        if (verified_beats_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none actual %06h last %0b",
                   $time, m_axis_tdata, m_axis_tlast);
          err_cnt++;
        end else begin
          exp_beat = verified_beats_q.pop_front();
          check_field("frame_byte", 32'(exp_beat.data), 32'(m_axis_tdata[7:0]));
          check_field("byte_index", 32'(exp_beat.idx), 32'(m_axis_tdata[13:8]));
          check_field("frame_length", 32'(exp_beat.len), 32'(m_axis_tdata[20:14]));
          check_field("pad", 0, 32'(m_axis_tdata[23:21]));
          check_field("tlast", 32'(exp_beat.last), 32'(m_axis_tlast));
        end
      end
      if (sink_gap != 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        sink_gap = int'($urandom_range(0, 13));
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cyc <= 0;
      end else if (idle_cyc >= WatchLimit) begin
        $display("%0t: no beat accepted for %0d cycles", $time, idle_cyc);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cyc <= idle_cyc + 1;
      end
    end
  end

  initial begin : stimulus
    int unsigned base;
    int unsigned noise_cnt;
    int unsigned r;
    bit          held;

    add_noise(1);
    rx_q.push_back(32'h00);
    rx_q.push_back(32'hFF);
    add_frame(0, 1'b1, -1);
    add_frame(0, 1'b0, -1);
    add_frame(1, 1'b1, 0);
    add_frame(1, 1'b1, 255);
    add_frame(3, 1'b1, int'(sapi_pkg::StartByte));
    add_frame(2, 1'b0, -1);
    add_frame(sapi_pkg::MaxFrameData, 1'b1, -1);
    add_frame(sapi_pkg::MaxFrameData + 1, 1'b1, -1);
    add_frame(5, 1'b1, -1);

    base = rx_q.size();
    noise_cnt = 0;
    held = 1'b0;
    while (rx_q.size() - base - noise_cnt < RandomBytes) begin
      if (!held && rx_q.size() - base > RandomBytes / 2) begin
        rx_q.push_back(NoiseMark);
        held = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 50) begin
        add_frame($urandom_range(0, 8), 1'b1, -1);
      end else if (r < 75) begin
        add_frame($urandom_range(9, sapi_pkg::MaxFrameData - 1), 1'b1, -1);
      end else if (r < 79) begin
        add_frame(sapi_pkg::MaxFrameData, 1'b1, -1);
      end else if (r < 89) begin
        add_frame($urandom_range(0, 20), 1'b0, -1);
      end else if (r < 94) begin
        add_frame($urandom_range(sapi_pkg::MaxFrameData + 1, 120), 1'b1, -1);
      end else begin
        r = $urandom_range(1, 4);
        add_noise(r);
        noise_cnt += r;
      end
    end
    stim_total = rx_q.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (rx_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (verified_beats_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    $display("Sent %0d serial bytes; checked %0d frame beats.", sent_cnt, beats_checked);
    $display("Frames: %0d verified, %0d dropped on checksum, %0d oversized skipped.",
             n_verified, n_dropped, n_oversized);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[serial_api_frame_receiver.f]
+incdir+design
design/sapi_pkg.sv
design/sapi_ctrl.sv
design/sapi_dp.sv
design/serial_api_frame_receiver.sv
sim/tb_top.sv
